// ===== rtl/ubdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the UART baud divisor calculator.
package ubdc_pkg;

    localparam longint unsigned BASE_CLOCK_HZ = 64'd48000000;

    // Accepted rate range: slowest and fastest line speeds the scheme can reach.
    localparam longint unsigned MIN_BPS = (BASE_CLOCK_HZ + 64'd1048575) / 64'd1048576;
    localparam longint unsigned MAX_BPS = BASE_CLOCK_HZ / 64'd16;

    localparam int SPD_W = $clog2(MAX_BPS + 64'd1);
    // A rate above its prescale threshold keeps the coarse divisor below 512.
    localparam int Q1_W  = 9;
    localparam int N1_W  = $clog2((BASE_CLOCK_HZ >> 2) + 64'd1);
    localparam int CW    = SPD_W + Q1_W;
    localparam int DIV_W = 8;
    localparam int DR_W  = DIV_W + 1;
    localparam int N2_W  = $clog2(BASE_CLOCK_HZ * 64'd4 + 64'd1);

    // Minimum rate of each prescale, indexed by prescale.
    localparam longint unsigned THR [4] = '{
        BASE_CLOCK_HZ / (64'd2048 * 64'd512),
        BASE_CLOCK_HZ / (64'd256 * 64'd512),
        BASE_CLOCK_HZ / (64'd32 * 64'd512),
        BASE_CLOCK_HZ / (64'd4 * 64'd512)
    };

    localparam logic [Q1_W-1:0]  DIV_LO   = Q1_W'(9);
    localparam logic [Q1_W-1:0]  DIV_HI   = Q1_W'(255);
    localparam logic [DIV_W-1:0] DIV_MIN  = DIV_W'(2);
    localparam logic [15:0]      WORD_BAD = 16'h0080;

    typedef logic [1:0] t_ps;
    localparam t_ps PS_0   = 2'd0;
    localparam t_ps PS_1   = 2'd1;
    localparam t_ps PS_2   = 2'd2;
    localparam t_ps PS_TOP = 2'd3;

    typedef struct packed {
        logic [SPD_W-1:0] speed;
        logic [DIV_W-1:0] div;
        t_ps              ps;
        logic             fact;
        logic             invalid;
    } t_side;

    // Base clock divided by the prescale clock divider at fact 1.
    function automatic logic [N1_W-1:0] n1_of(input t_ps ps);
        int sh;
        sh = 11 - 3 * int'(ps);
        return N1_W'(BASE_CLOCK_HZ >> sh);
    endfunction

    // Sixteen times the base clock over the full clock divider.
    function automatic logic [N2_W-1:0] n2_of(input t_ps ps, input logic fact);
        int sh;
        sh = 12 - 3 * int'(ps) - int'(fact);
        return N2_W'((BASE_CLOCK_HZ * 64'd16) >> sh);
    endfunction

endpackage

// ===== rtl/ubdc_fine_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one numerator by div and by div+1, one bit per stage.
module ubdc_fine_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [ubdc_pkg::N2_W-1:0]  i_num,
    input  ubdc_pkg::t_side            i_side,
    output logic                       o_valid,
    output logic [ubdc_pkg::N2_W-1:0]  o_quo_lo,
    output logic [ubdc_pkg::N2_W-1:0]  o_quo_hi,
    output ubdc_pkg::t_side            o_side
);
    import ubdc_pkg::*;

    logic              r_vld    [N2_W];
    logic [N2_W-1:0]   r_num    [N2_W];
    logic [DR_W-1:0]   r_rem_lo [N2_W];
    logic [DR_W-1:0]   r_rem_hi [N2_W];
    logic [N2_W-1:0]   r_quo_lo [N2_W];
    logic [N2_W-1:0]   r_quo_hi [N2_W];
    t_side             r_side   [N2_W];

    for (genvar k = 0; k < N2_W; k++) begin : g_stage
        logic            w_vld;
        logic [N2_W-1:0] w_num;
        logic [DR_W-1:0] w_rem_lo;
        logic [DR_W-1:0] w_rem_hi;
        logic [N2_W-1:0] w_quo_lo;
        logic [N2_W-1:0] w_quo_hi;
        t_side           w_side;
        logic [DR_W-1:0] w_den_lo;
        logic [DR_W-1:0] w_den_hi;
        logic [DR_W:0]   w_try_lo;
        logic [DR_W:0]   w_try_hi;
        logic            w_take_lo;
        logic            w_take_hi;

        if (k == 0) begin : g_first
            assign w_vld    = i_valid;
            assign w_num    = i_num;
            assign w_rem_lo = '0;
            assign w_rem_hi = '0;
            assign w_quo_lo = '0;
            assign w_quo_hi = '0;
            assign w_side   = i_side;
        end else begin : g_next
            assign w_vld    = r_vld[k-1];
            assign w_num    = r_num[k-1];
            assign w_rem_lo = r_rem_lo[k-1];
            assign w_rem_hi = r_rem_hi[k-1];
            assign w_quo_lo = r_quo_lo[k-1];
            assign w_quo_hi = r_quo_hi[k-1];
            assign w_side   = r_side[k-1];
        end

        assign w_den_lo  = DR_W'(w_side.div);
        assign w_den_hi  = w_den_lo + DR_W'(1);
        assign w_try_lo  = {w_rem_lo, w_num[N2_W-1]};
        assign w_try_hi  = {w_rem_hi, w_num[N2_W-1]};
        assign w_take_lo = w_try_lo >= {1'b0, w_den_lo};
        assign w_take_hi = w_try_hi >= {1'b0, w_den_hi};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]    <= w_num << 1;
                r_rem_lo[k] <= w_take_lo ? DR_W'(w_try_lo - {1'b0, w_den_lo}) : DR_W'(w_try_lo);
                r_rem_hi[k] <= w_take_hi ? DR_W'(w_try_hi - {1'b0, w_den_hi}) : DR_W'(w_try_hi);
                r_quo_lo[k] <= {w_quo_lo[N2_W-2:0], w_take_lo};
                r_quo_hi[k] <= {w_quo_hi[N2_W-2:0], w_take_hi};
                r_side[k]   <= w_side;
            end
        end
    end

    assign o_valid  = r_vld[N2_W-1];
    assign o_quo_lo = r_quo_lo[N2_W-1];
    assign o_quo_hi = r_quo_hi[N2_W-1];
    assign o_side   = r_side[N2_W-1];

endmodule

// ===== rtl/uart_baud_divisor_calc.sv =====
`timescale 1ns / 1ps
// Top level: requested baud rate in, 16-bit UART divisor register word out.
//
//   channel   direction  handshake                    payload
//   -------   ---------  ---------------------------  ---------------------------
//   in        to block   i_in_valid / o_in_stall      i_baud_rate
//   out       from block o_out_valid / i_out_stall    o_divisor_word, o_invalid
//   cfg       to block   i_cfg_we                     i_cfg_wdata (limited_prescaler)
//
// One beat enters per clock while o_in_stall is low. The pipe is built around
// the two bit-per-stage dividers: coarse divisor (9 stages) and the
// rounding quotients (one stage per numerator bit).
// i_rst_n is synchronous, active low; it clears all valid bits and the config bit.
// A two-entry output buffer decouples the sides: o_in_stall is registered and
// rises only when a result sits in the skid entry; the whole pipe then holds.
module uart_baud_divisor_calc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_baud_rate,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_divisor_word,
    output logic        o_invalid
);
    import ubdc_pkg::*;

    logic w_en;

    // config register
    logic r_lim;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= 1'b0;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_wdata;
        end
    end

    // stage 0: clamp the request into the reachable range
    logic             r_s0_vld;
    logic [SPD_W-1:0] r_s0_spd;
    logic [SPD_W-1:0] n_s0_spd;

    always_comb begin
        if (i_baud_rate < MIN_BPS) begin
            n_s0_spd = SPD_W'(MIN_BPS);
        end else if (i_baud_rate > MAX_BPS) begin
            n_s0_spd = SPD_W'(MAX_BPS);
        end else begin
            n_s0_spd = SPD_W'(i_baud_rate);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_spd <= n_s0_spd;
        end
    end

    // stage 1: pick the highest prescale whose floor lies below the rate
    logic             r_s1_vld;
    logic [SPD_W-1:0] r_s1_spd;
    t_ps              r_s1_ps;
    logic             r_s1_ok;
    logic [N1_W-1:0]  r_s1_num;
    t_ps              n_s1_ps;

    always_comb begin
        if (r_s0_spd > THR[3]) begin
            n_s1_ps = PS_TOP;
        end else if (r_s0_spd > THR[2]) begin
            n_s1_ps = PS_2;
        end else if (r_s0_spd > THR[1]) begin
            n_s1_ps = PS_1;
        end else begin
            n_s1_ps = PS_0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_spd <= r_s0_spd;
            r_s1_ps  <= n_s1_ps;
            r_s1_ok  <= r_s0_spd > THR[0];
            r_s1_num <= n1_of(n_s1_ps);
        end
    end

    // coarse divisor: restoring division, one quotient bit per stage, MSB first
    logic             r_c_vld [Q1_W];
    logic [N1_W-1:0]  r_c_rem [Q1_W];
    logic [Q1_W-1:0]  r_c_quo [Q1_W];
    logic [SPD_W-1:0] r_c_spd [Q1_W];
    t_ps              r_c_ps  [Q1_W];
    logic             r_c_ok  [Q1_W];

    for (genvar j = 0; j < Q1_W; j++) begin : g_coarse
        logic             w_vld;
        logic [N1_W-1:0]  w_rem;
        logic [Q1_W-1:0]  w_quo;
        logic [SPD_W-1:0] w_spd;
        t_ps              w_ps;
        logic             w_ok;
        logic [CW-1:0]    w_trial;
        logic             w_take;

        if (j == 0) begin : g_first
            assign w_vld = r_s1_vld;
            assign w_rem = r_s1_num;
            assign w_quo = '0;
            assign w_spd = r_s1_spd;
            assign w_ps  = r_s1_ps;
            assign w_ok  = r_s1_ok;
        end else begin : g_next
            assign w_vld = r_c_vld[j-1];
            assign w_rem = r_c_rem[j-1];
            assign w_quo = r_c_quo[j-1];
            assign w_spd = r_c_spd[j-1];
            assign w_ps  = r_c_ps[j-1];
            assign w_ok  = r_c_ok[j-1];
        end

        assign w_trial = CW'(w_spd) << (Q1_W - 1 - j);
        assign w_take  = CW'(w_rem) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[j] <= 1'b0;
            end else if (w_en) begin
                r_c_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c_rem[j] <= w_take ? N1_W'(CW'(w_rem) - w_trial) : w_rem;
                r_c_quo[j] <= {w_quo[Q1_W-2:0], w_take};
                r_c_spd[j] <= w_spd;
                r_c_ps[j]  <= w_ps;
                r_c_ok[j]  <= w_ok;
            end
        end
    end

    // adjust: drop to the halved base clock when the divisor is out of range
    // or the limited-prescaler mode asks for it
    logic             r_a_vld;
    t_side            r_a_side;
    logic [N2_W-1:0]  r_a_num;
    logic [Q1_W-1:0]  w_q1;
    t_ps              w_a_ps;
    logic             w_half;
    logic [DIV_W-1:0] w_a_div;
    t_side            n_a_side;

    assign w_q1    = r_c_quo[Q1_W-1];
    assign w_a_ps  = r_c_ps[Q1_W-1];
    assign w_half  = (w_q1 < DIV_LO) || (w_q1 > DIV_HI) || ((w_a_ps != PS_TOP) && r_lim);
    assign w_a_div = w_half ? DIV_W'(w_q1 >> 1) : DIV_W'(w_q1);

    always_comb begin
        n_a_side.speed   = r_c_spd[Q1_W-1];
        n_a_side.div     = w_a_div;
        n_a_side.ps      = w_a_ps;
        n_a_side.fact    = !w_half;
        n_a_side.invalid = !r_c_ok[Q1_W-1] || (w_a_div < DIV_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= r_c_vld[Q1_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_side <= n_a_side;
            r_a_num  <= n2_of(w_a_ps, !w_half);
        end
    end

    // rates for div and div+1, sixteen times oversampled
    logic            w_f_vld;
    logic [N2_W-1:0] w_qa;
    logic [N2_W-1:0] w_qb;
    t_side           w_f_side;

    ubdc_fine_div u_fine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_a_vld),
        .i_num    (r_a_num),
        .i_side   (r_a_side),
        .o_valid  (w_f_vld),
        .o_quo_lo (w_qa),
        .o_quo_hi (w_qb),
        .o_side   (w_f_side)
    );

    // round: take div+1 when it lands no farther from the request,
    // i.e. rate(div) + rate(div+1) >= 2 * 16 * speed
    logic            r_r_vld;
    logic [DR_W-1:0] r_r_div;
    logic            r_r_fact;
    t_ps             r_r_ps;
    logic            r_r_inv;
    logic [N2_W:0]   w_sum;
    logic [N2_W:0]   w_goal;
    logic            w_up;
    logic [DR_W-1:0] w_rdiv;
    logic [DR_W-1:0] n_r_div;
    logic            n_r_fact;

    assign w_sum  = (N2_W+1)'(w_qa) + (N2_W+1)'(w_qb);
    assign w_goal = (N2_W+1)'(w_f_side.speed) << 5;
    assign w_up   = w_sum >= w_goal;
    assign w_rdiv = DR_W'(w_f_side.div) + DR_W'(w_up);

    always_comb begin
        if (w_f_side.fact && !w_rdiv[0]) begin
            n_r_div  = w_rdiv >> 1;
            n_r_fact = 1'b0;
        end else begin
            n_r_div  = w_rdiv;
            n_r_fact = w_f_side.fact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
        end else if (w_en) begin
            r_r_vld <= w_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r_div  <= n_r_div;
            r_r_fact <= n_r_fact;
            r_r_ps   <= w_f_side.ps;
            r_r_inv  <= w_f_side.invalid;
        end
    end

    // pack the register word; a divisor of 256 gives a zero high byte
    logic [DR_W-1:0] w_neg;
    logic [15:0]     w_word;

    assign w_neg  = DR_W'(256) - r_r_div;
    assign w_word = r_r_inv ? WORD_BAD : {w_neg[7:0], 1'b1, 4'b0000, r_r_fact, r_r_ps};

    // output register plus skid entry
    logic        r_out_vld;
    logic [15:0] r_out_word;
    logic        r_out_inv;
    logic        r_skid_vld;
    logic [15:0] r_skid_word;
    logic        r_skid_inv;
    logic        w_push;
    logic        w_pop;

    assign w_en   = !r_skid_vld;
    assign w_push = r_r_vld && w_en;
    assign w_pop  = r_out_vld && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_pop || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_push;
            end
        end else if (w_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_word <= r_skid_word;
                r_out_inv  <= r_skid_inv;
            end else begin
                r_out_word <= w_word;
                r_out_inv  <= r_r_inv;
            end
        end else if (w_push) begin
            r_skid_word <= w_word;
            r_skid_inv  <= r_r_inv;
        end
    end

    assign o_in_stall     = r_skid_vld;
    assign o_out_valid    = r_out_vld;
    assign o_divisor_word = r_out_word;
    assign o_invalid      = r_out_inv;

endmodule

// ===== rtl/ubdc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the UART baud divisor calculator, bound to the top level.
module ubdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_divisor_word,
    input logic        o_invalid
);
    import ubdc_pkg::*;

    // reset empties the block
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // input backs up only behind a pending result
    a_stall_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_divisor_word)
                                       && $stable(o_invalid))
        else $error("stalled result beat changed");

    // word format: bit 7 set, bits 6:3 clear, fixed word when invalid
    a_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_divisor_word[7] && (o_divisor_word[6:3] == 4'b0000)
                        && (!o_invalid || (o_divisor_word == WORD_BAD)))
        else $error("malformed divisor word");

endmodule

bind uart_baud_divisor_calc ubdc_checker u_ubdc_checker (.*);
